FILE: hdl/jad_pkg.sv
// Shared types, constants and the word decode function for the joystick
// autorange direction block. No dependencies.
`timescale 1ns / 1ps

package jad_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int WORD_W      = 16;
    localparam int POS_SHIFT   = WORD_W - SAMPLE_BITS;
    localparam int OUT_POS_W   = 12;
    localparam int THRESH_W    = 10;
    localparam int STEP_W      = 7;
    localparam int VOL_W       = 7;
    localparam int PAGE_W      = 2;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    // 2023 * (2^SAMPLE_BITS - 1) stays below 2^(SAMPLE_BITS + 11), plus sign
    localparam int PROD_W      = SAMPLE_BITS + 12;
    localparam int LHS_SCALE   = 2000;
    localparam int UNIT_SCALE  = 1000;

    localparam logic [THRESH_W-1:0]    THRESH_RESET = THRESH_W'(700);
    localparam logic [STEP_W-1:0]      STEP_RESET   = STEP_W'(5);
    localparam logic [VOL_W-1:0]       LIMIT_RESET  = VOL_W'(100);
    localparam logic [VOL_W-1:0]       VOLUME_RESET = VOL_W'(50);
    localparam logic [PAGE_W-1:0]      PAGE_RESET   = PAGE_W'(1);
    localparam logic [SAMPLE_BITS-1:0] X_LOW_RESET  = SAMPLE_BITS'(18);
    localparam logic [SAMPLE_BITS-1:0] X_HIGH_RESET = SAMPLE_BITS'(1644);
    localparam logic [SAMPLE_BITS-1:0] Y_LOW_RESET  = SAMPLE_BITS'(8);
    localparam logic [SAMPLE_BITS-1:0] Y_HIGH_RESET = SAMPLE_BITS'(1635);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [WORD_W-1:0]      word_t;
    typedef logic [THRESH_W-1:0]    thresh_t;
    typedef logic [STEP_W-1:0]      step_t;
    typedef logic [VOL_W-1:0]       volume_t;
    typedef logic [PAGE_W-1:0]      page_t;
    typedef logic [OUT_POS_W-1:0]   out_pos_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [DATA_W-1:0]      data_t;

    typedef enum logic [2:0] {
        DIR_CENTER = 3'd0,
        DIR_RIGHT  = 3'd1,
        DIR_LEFT   = 3'd2,
        DIR_UP     = 3'd3,
        DIR_DOWN   = 3'd4
    } dir_t;

    typedef enum logic [1:0] {
        SENSE_MID  = 2'd0,
        SENSE_HIGH = 2'd1,
        SENSE_LOW  = 2'd2
    } sense_t;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_STEP      = 2'd1,
        REG_LIMIT     = 2'd2
    } reg_index_t;

    typedef struct packed {
        sample_t low;
        sample_t high;
        sense_t  sense;
    } axis_result_t;

    // bus word arrives byte swapped; top SAMPLE_BITS bits are the position
    function automatic sample_t decode_word(input word_t w);
        word_t sw;
        sw = {w[7:0], w[15:8]};
        return sw[WORD_W-1:POS_SHIFT];
    endfunction

endpackage

FILE: hdl/jad_axis_classify.sv
// One axis: widens the tracked range with the new position and classifies
// the deflection against the threshold. Depends on jad_pkg.
`timescale 1ns / 1ps

module jad_axis_classify (
    input  jad_pkg::sample_t      pos,
    input  jad_pkg::sample_t      low,
    input  jad_pkg::sample_t      high,
    input  jad_pkg::thresh_t      threshold,
    output jad_pkg::axis_result_t result
);
    import jad_pkg::*;

    sample_t                   low_w;
    sample_t                   high_w;
    logic signed [PROD_W-1:0]  q_s;
    logic signed [PROD_W-1:0]  d_s;
    logic signed [PROD_W-1:0]  t_s;
    logic signed [PROD_W-1:0]  lhs;
    logic signed [PROD_W-1:0]  rhs_high;
    logic signed [PROD_W-1:0]  rhs_low;

    always_comb begin
        low_w    = (pos < low)  ? pos : low;
        high_w   = (pos > high) ? pos : high;
        q_s      = signed'(PROD_W'(pos - low_w));
        d_s      = signed'(PROD_W'(high_w - low_w));
        t_s      = signed'(PROD_W'(threshold));
        lhs      = PROD_W'(LHS_SCALE) * q_s;
        rhs_high = (PROD_W'(UNIT_SCALE) + t_s) * d_s;
        rhs_low  = (PROD_W'(UNIT_SCALE) - t_s) * d_s;

        result.low  = low_w;
        result.high = high_w;
        if (lhs > rhs_high) begin
            result.sense = SENSE_HIGH;
        end else if (lhs < rhs_low) begin
            result.sense = SENSE_LOW;
        end else begin
            result.sense = SENSE_MID;
        end
    end

endmodule

FILE: hdl/joystick_autorange_direction.sv
// Top level: APB register file, input register, classification of both axes,
// volume and page update, result register. Depends on jad_pkg, jad_axis_classify.
//
//   channel  direction  handshake        payload
//   s_       in         s_valid/s_ready  kind, raw_x_word, raw_y_word
//   m_       out        m_valid/m_ready  direction, volume_level, page, x_pos, y_pos
//   apb      in/out     psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One request per cycle sustained while m_ready holds; m_valid rises after the input
// and result registers. The range and volume update is a loop through the two axis
// multipliers and the compare, closed by the range and volume registers. Reset is
// synchronous, active low, and restores the reset ranges, volume and page. A stalled
// result holds while one more request can still be taken into the input register.
`timescale 1ns / 1ps

module joystick_autorange_direction (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  jad_pkg::addr_t    paddr,
    input  jad_pkg::data_t    pwdata,
    output jad_pkg::data_t    prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  jad_pkg::word_t    s_raw_x_word,
    input  jad_pkg::word_t    s_raw_y_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_direction,
    output jad_pkg::volume_t  m_volume_level,
    output jad_pkg::page_t    m_page,
    output jad_pkg::out_pos_t m_x_pos,
    output jad_pkg::out_pos_t m_y_pos
);
    import jad_pkg::*;

    thresh_t    threshold_reg;
    step_t      step_reg;
    volume_t    limit_reg;
    reg_index_t reg_index;
    logic       cfg_write;

    logic       in_valid_reg;
    logic       in_kind_reg;
    word_t      in_x_word_reg;
    word_t      in_y_word_reg;

    logic       out_valid_reg;
    dir_t       out_dir_reg;
    volume_t    out_volume_reg;
    page_t      out_page_reg;
    out_pos_t   out_x_reg;
    out_pos_t   out_y_reg;

    sample_t    x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    sample_t    x_low_next, x_high_next, y_low_next, y_high_next;
    volume_t    volume_reg, volume_next;
    page_t      page_reg, page_next;
    dir_t       dir_next;
    out_pos_t   x_out_next, y_out_next;

    sample_t      x_pos, y_pos;
    axis_result_t x_res, y_res;
    logic [VOL_W:0] vol_sum;
    logic       out_load;
    logic       in_load;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_index)
            REG_THRESHOLD: prdata = DATA_W'(threshold_reg);
            REG_STEP:      prdata = DATA_W'(step_reg);
            REG_LIMIT:     prdata = DATA_W'(limit_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESH_RESET;
            step_reg      <= STEP_RESET;
            limit_reg     <= LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_THRESHOLD: threshold_reg <= pwdata[THRESH_W-1:0];
                REG_STEP:      step_reg      <= pwdata[STEP_W-1:0];
                REG_LIMIT:     limit_reg     <= pwdata[VOL_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_kind_reg   <= s_kind;
            in_x_word_reg <= s_raw_x_word;
            in_y_word_reg <= s_raw_y_word;
        end
        if (out_load) begin
            out_dir_reg    <= dir_next;
            out_volume_reg <= volume_next;
            out_page_reg   <= page_next;
            out_x_reg      <= x_out_next;
            out_y_reg      <= y_out_next;
        end
    end

    // ---------------- datapath ----------------
    assign x_pos = decode_word(in_x_word_reg);
    assign y_pos = decode_word(in_y_word_reg);

    jad_axis_classify u_x_axis (
        .pos       (x_pos),
        .low       (x_low_reg),
        .high      (x_high_reg),
        .threshold (threshold_reg),
        .result    (x_res)
    );

    jad_axis_classify u_y_axis (
        .pos       (y_pos),
        .low       (y_low_reg),
        .high      (y_high_reg),
        .threshold (threshold_reg),
        .result    (y_res)
    );

    assign vol_sum = {1'b0, volume_reg} + {1'b0, step_reg};

    always_comb begin
        dir_next    = DIR_CENTER;
        volume_next = volume_reg;
        page_next   = page_reg;
        x_low_next  = x_low_reg;
        x_high_next = x_high_reg;
        y_low_next  = y_low_reg;
        y_high_next = y_high_reg;
        x_out_next  = '0;
        y_out_next  = '0;
        if (in_kind_reg) begin
            case (page_reg)
                2'd1:    page_next = 2'd2;
                2'd2:    page_next = 2'd3;
                default: page_next = 2'd1;
            endcase
        end else begin
            x_low_next  = x_res.low;
            x_high_next = x_res.high;
            y_low_next  = y_res.low;
            y_high_next = y_res.high;
            x_out_next  = OUT_POS_W'(x_pos);
            y_out_next  = OUT_POS_W'(y_pos);
            // Y is inverted: low deflection means up
            if (x_res.sense == SENSE_HIGH) begin
                dir_next = DIR_RIGHT;
            end else if (x_res.sense == SENSE_LOW) begin
                dir_next = DIR_LEFT;
            end else if (y_res.sense == SENSE_LOW) begin
                dir_next = DIR_UP;
            end else if (y_res.sense == SENSE_HIGH) begin
                dir_next = DIR_DOWN;
            end
            if (dir_next == DIR_UP) begin
                if (vol_sum <= {1'b0, limit_reg}) begin
                    volume_next = vol_sum[VOL_W-1:0];
                end
            end else if (dir_next == DIR_DOWN) begin
                if (volume_reg >= step_reg) begin
                    volume_next = volume_reg - step_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_low_reg  <= X_LOW_RESET;
            x_high_reg <= X_HIGH_RESET;
            y_low_reg  <= Y_LOW_RESET;
            y_high_reg <= Y_HIGH_RESET;
            volume_reg <= VOLUME_RESET;
            page_reg   <= PAGE_RESET;
        end else if (out_load) begin
            x_low_reg  <= x_low_next;
            x_high_reg <= x_high_next;
            y_low_reg  <= y_low_next;
            y_high_reg <= y_high_next;
            volume_reg <= volume_next;
            page_reg   <= page_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_direction    = out_dir_reg;
    assign m_volume_level = out_volume_reg;
    assign m_page         = out_page_reg;
    assign m_x_pos        = out_x_reg;
    assign m_y_pos        = out_y_reg;

    // ---------------- assertions ----------------
    a_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        x_low_reg <= x_high_reg)
        else $error("x range inverted");

    a_y_range: assert property (@(posedge aclk) disable iff (!aresetn)
        y_low_reg <= y_high_reg)
        else $error("y range inverted");

    a_page_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        page_reg != 2'd0)
        else $error("page register is zero");

    a_button_center: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && in_kind_reg |=> m_valid && m_direction == DIR_CENTER
            && m_x_pos == '0 && m_y_pos == '0)
        else $error("button request gave a direction or position");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a full pipeline");

endmodule
